// File: sv/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types for the assembler line tokenizer: token kinds, lexer modes,
// radix codes and the result batch passed from the lexer core to the top.
// ----------------------------------------------------------------------------
package alt_pkg;

  localparam int MaxResults = 4;
  localparam int CountW     = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    K_END   = 4'd0,
    K_IDENT = 4'd1,
    K_REG   = 4'd2,
    K_NUM   = 4'd3,
    K_LABEL = 4'd4,
    K_STR   = 4'd5,
    K_SHL   = 4'd6,
    K_SHR   = 4'd7,
    K_PUNCT = 4'd8,
    K_TEXT  = 4'd9
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_DOT,
    M_DOLLAR,
    M_NUM,
    M_ZERO,
    M_ZEROX,
    M_LABEL,
    M_STRING,
    M_LT,
    M_GT,
    M_COMMENT
  } mode_t;

  typedef enum logic [1:0] {
    R_DEC,
    R_OCT,
    R_HEX
  } radix_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        backward;
    logic        error;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0]             count;
    result_t [MaxResults-1:0]      item;
  } batch_t;

endpackage

// File: sv/alt_core.sv
// ----------------------------------------------------------------------------
// alt_core
// Lexer state and the single-pass decode of one character into up to four
// results. State advances when the top level takes the character.
// ----------------------------------------------------------------------------
module alt_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      ch,
  output alt_pkg::batch_t batch
);

  localparam int CountW_L = alt_pkg::CountW;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChUnder  = 8'h5F;

  typedef enum logic [1:0] {
    T_NONE,
    T_IDLE,
    T_IDENT
  } tail_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == ChUnder;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {hit, index}
  function automatic logic [5:0] reg_index(input logic [23:0] mc, input logic [2:0] ml);
    logic [5:0] r;
    r = 6'd0;
    if (ml == 3'd2) begin
      if (mc[15:8] == "S" && mc[7:0] == "P") begin
        r = {1'b1, 5'd15};
      end else if (is_digit(mc[7:0]) && mc[15:8] == "A") begin
        r = {2'b10, mc[3:0]};
      end else if (is_digit(mc[7:0]) && mc[15:8] == "B") begin
        r = {2'b11, mc[3:0]};
      end
    end else if (ml == 3'd3 && mc[15:8] == "1") begin
      if (mc[23:16] == "A" && mc[7:0] >= "0" && mc[7:0] <= "4") begin
        r = {1'b1, 5'd10 + {1'b0, mc[3:0]}};
      end else if (mc[23:16] == "B" && mc[7:0] >= "0" && mc[7:0] <= "5") begin
        r = {1'b1, 5'd26 + {1'b0, mc[3:0]}};
      end
    end
    return r;
  endfunction

  function automatic alt_pkg::result_t mk(input alt_pkg::kind_t k, input logic [31:0] v,
                                          input logic b, input logic e);
    alt_pkg::result_t r;
    r.kind     = k;
    r.value    = v;
    r.backward = b;
    r.error    = e;
    r.last     = 1'b0;
    return r;
  endfunction

  alt_pkg::mode_t  mode, mode_next;
  logic [31:0]     accum, accum_next;
  alt_pkg::radix_t radix, radix_next;
  logic            saturated, saturated_next;
  logic [23:0]     match_chars, match_chars_next;
  logic [2:0]      match_len, match_len_next;
  logic [7:0]      pending_char, pending_char_next;

  // from-idle decode
  logic             idle_hit;
  alt_pkg::result_t idle_res;
  alt_pkg::mode_t   idle_mode;
  logic [31:0]      idle_accum;
  alt_pkg::radix_t  idle_radix;
  logic [23:0]      idle_mc;
  logic [2:0]       idle_ml;

  always_comb begin
    idle_hit   = 1'b0;
    idle_res   = mk(alt_pkg::K_END, 32'd0, 1'b0, 1'b0);
    idle_mode  = alt_pkg::M_IDLE;
    idle_accum = 32'd0;
    idle_radix = alt_pkg::R_DEC;
    idle_mc    = 24'd0;
    idle_ml    = 3'd0;
    if (ch == ChSpace || ch == ChTab) begin
      idle_hit = 1'b0;
    end else if (is_alpha(ch) || ch == ChUnder) begin
      idle_hit  = 1'b1;
      idle_res  = mk(alt_pkg::K_TEXT, {24'd0, ch}, 1'b0, 1'b0);
      idle_mode = alt_pkg::M_IDENT;
      idle_mc   = {16'd0, to_upper(ch)};
      idle_ml   = 3'd1;
    end else if (ch == ChDot) begin
      idle_mode = alt_pkg::M_DOT;
    end else if (ch == ChDollar) begin
      idle_mode  = alt_pkg::M_DOLLAR;
      idle_radix = alt_pkg::R_HEX;
    end else if (ch == "0") begin
      idle_mode  = alt_pkg::M_ZERO;
      idle_radix = alt_pkg::R_OCT;
    end else if (is_digit(ch)) begin
      idle_mode  = alt_pkg::M_NUM;
      idle_accum = {28'd0, ch[3:0]};
    end else if (ch == ChNl || ch == ChNul) begin
      idle_hit = 1'b1;
    end else if (ch == ChSemi) begin
      idle_hit  = 1'b1;
      idle_mode = alt_pkg::M_COMMENT;
    end else if (ch == ChQuote) begin
      idle_mode = alt_pkg::M_STRING;
    end else if (ch == ChLt) begin
      idle_mode = alt_pkg::M_LT;
    end else if (ch == ChGt) begin
      idle_mode = alt_pkg::M_GT;
    end else begin
      idle_hit = 1'b1;
      idle_res = mk(alt_pkg::K_PUNCT, {24'd0, ch}, 1'b0, 1'b0);
    end
  end

  // number digit and accumulate
  logic [4:0]  hex;
  logic        dig_ok;
  logic [35:0] prod;
  logic [35:0] sum;

  always_comb begin
    hex = hex_digit(ch);
    case (radix)
      alt_pkg::R_HEX: begin
        dig_ok = hex[4];
        prod   = {accum, 4'd0};
      end
      alt_pkg::R_OCT: begin
        dig_ok = hex[4] && hex[3:0] < 4'd8;
        prod   = {1'b0, accum, 3'd0};
      end
      default: begin
        dig_ok = hex[4] && hex[3:0] < 4'd10;
        prod   = {1'b0, accum, 3'd0} + {3'd0, accum, 1'b0};
      end
    endcase
    sum = prod + {32'd0, hex[3:0]};
  end

  // main decode
  alt_pkg::result_t pre0, pre1, tail0, tail1;
  logic [1:0]       pcount, tcount;
  tail_t            tail;
  logic [23:0]      t_mc;
  logic [2:0]       t_ml;
  logic [5:0]       rix;
  logic [7:0]       up;
  logic [CountW_L-1:0] n;

  always_comb begin
    mode_next         = mode;
    accum_next        = accum;
    radix_next        = radix;
    saturated_next    = saturated;
    match_chars_next  = match_chars;
    match_len_next    = match_len;
    pending_char_next = pending_char;
    pre0   = mk(alt_pkg::K_END, 32'd0, 1'b0, 1'b0);
    pre1   = pre0;
    tail0  = pre0;
    tail1  = pre0;
    pcount = 2'd0;
    tcount = 2'd0;
    tail   = T_NONE;
    t_mc   = match_chars;
    t_ml   = match_len;
    up     = to_upper(pending_char);

    case (mode)
      alt_pkg::M_IDENT: begin
        tail = T_IDENT;
      end
      alt_pkg::M_DOT: begin
        if (is_word(ch)) begin
          pre0   = mk(alt_pkg::K_TEXT, {24'd0, ChDot}, 1'b0, 1'b0);
          pcount = 2'd1;
          tail   = T_IDENT;
          t_mc   = {16'd0, ChDot};
          t_ml   = 3'd1;
        end else begin
          pre0   = mk(alt_pkg::K_PUNCT, {24'd0, ChDot}, 1'b0, 1'b0);
          pcount = 2'd1;
          tail   = T_IDLE;
        end
      end
      alt_pkg::M_DOLLAR: begin
        if (hex[4]) begin
          mode_next  = alt_pkg::M_NUM;
          accum_next = {28'd0, hex[3:0]};
        end else begin
          pre0   = mk(alt_pkg::K_NUM, 32'd0, 1'b0, 1'b1);
          pcount = 2'd1;
          tail   = T_IDLE;
        end
      end
      alt_pkg::M_ZEROX: begin
        if (hex[4]) begin
          mode_next  = alt_pkg::M_NUM;
          radix_next = alt_pkg::R_HEX;
          accum_next = {28'd0, hex[3:0]};
        end else begin
          pre0   = mk(alt_pkg::K_NUM, 32'd0, 1'b0, 1'b0);
          pre1   = mk(alt_pkg::K_TEXT, {24'd0, pending_char}, 1'b0, 1'b0);
          pcount = 2'd2;
          tail   = T_IDENT;
          t_mc   = {16'd0, up};
          t_ml   = 3'd1;
        end
      end
      alt_pkg::M_ZERO, alt_pkg::M_NUM: begin
        if (mode == alt_pkg::M_ZERO && (ch == "x" || ch == "X")) begin
          mode_next         = alt_pkg::M_ZEROX;
          pending_char_next = ch;
        end else if (dig_ok) begin
          mode_next = alt_pkg::M_NUM;
          if (!saturated) begin
            if (|sum[35:32]) begin
              accum_next     = '1;
              saturated_next = 1'b1;
            end else begin
              accum_next = sum[31:0];
            end
          end
        end else if (radix != alt_pkg::R_HEX &&
                     (ch == "f" || ch == "F" || ch == "b" || ch == "B")) begin
          mode_next         = alt_pkg::M_LABEL;
          pending_char_next = ch;
        end else begin
          pre0   = mk(alt_pkg::K_NUM, accum, 1'b0, 1'b0);
          pcount = 2'd1;
          tail   = T_IDLE;
        end
      end
      alt_pkg::M_LABEL: begin
        if (is_word(ch)) begin
          pre0   = mk(alt_pkg::K_NUM, accum, 1'b0, 1'b0);
          pre1   = mk(alt_pkg::K_TEXT, {24'd0, pending_char}, 1'b0, 1'b0);
          pcount = 2'd2;
          tail   = T_IDENT;
          t_mc   = {16'd0, up};
          t_ml   = 3'd1;
        end else begin
          pre0   = mk(alt_pkg::K_LABEL, accum, up == "B", 1'b0);
          pcount = 2'd1;
          tail   = T_IDLE;
        end
      end
      alt_pkg::M_STRING: begin
        if (ch == ChQuote) begin
          pre0      = mk(alt_pkg::K_STR, 32'd0, 1'b0, 1'b0);
          pcount    = 2'd1;
          mode_next = alt_pkg::M_IDLE;
        end else if (ch == ChNl || ch == ChNul) begin
          pre0      = mk(alt_pkg::K_STR, 32'd0, 1'b0, 1'b1);
          pre1      = mk(alt_pkg::K_END, 32'd0, 1'b0, 1'b0);
          pcount    = 2'd2;
          mode_next = alt_pkg::M_IDLE;
        end else begin
          pre0   = mk(alt_pkg::K_TEXT, {24'd0, ch}, 1'b0, 1'b0);
          pcount = 2'd1;
        end
        if (mode_next == alt_pkg::M_IDLE) begin
          accum_next        = 32'd0;
          radix_next        = alt_pkg::R_DEC;
          saturated_next    = 1'b0;
          match_chars_next  = 24'd0;
          match_len_next    = 3'd0;
          pending_char_next = 8'd0;
        end
      end
      alt_pkg::M_LT, alt_pkg::M_GT: begin
        if ((mode == alt_pkg::M_LT && ch == ChLt) || (mode == alt_pkg::M_GT && ch == ChGt)) begin
          pre0 = mk((mode == alt_pkg::M_LT) ? alt_pkg::K_SHL : alt_pkg::K_SHR,
                    32'd0, 1'b0, 1'b0);
          pcount            = 2'd1;
          mode_next         = alt_pkg::M_IDLE;
          accum_next        = 32'd0;
          radix_next        = alt_pkg::R_DEC;
          saturated_next    = 1'b0;
          match_chars_next  = 24'd0;
          match_len_next    = 3'd0;
          pending_char_next = 8'd0;
        end else begin
          pre0   = mk(alt_pkg::K_PUNCT, (mode == alt_pkg::M_LT) ? {24'd0, ChLt} : {24'd0, ChGt},
                      1'b0, 1'b0);
          pcount = 2'd1;
          tail   = T_IDLE;
        end
      end
      alt_pkg::M_COMMENT: begin
        if (ch == ChNl || ch == ChNul) begin
          mode_next         = alt_pkg::M_IDLE;
          accum_next        = 32'd0;
          radix_next        = alt_pkg::R_DEC;
          saturated_next    = 1'b0;
          match_chars_next  = 24'd0;
          match_len_next    = 3'd0;
          pending_char_next = 8'd0;
        end
      end
      default: begin
        tail = T_IDLE;
      end
    endcase

    rix = reg_index(t_mc, t_ml);
    if (tail == T_IDENT && is_word(ch)) begin
      tail0     = mk(alt_pkg::K_TEXT, {24'd0, ch}, 1'b0, 1'b0);
      tcount    = 2'd1;
      mode_next = alt_pkg::M_IDENT;
      match_chars_next = (t_ml < 3'd3) ? {t_mc[15:0], to_upper(ch)} : t_mc;
      match_len_next   = (t_ml < 3'd7) ? t_ml + 3'd1 : t_ml;
    end else if (tail != T_NONE) begin
      if (tail == T_IDENT) begin
        tail0  = rix[5] ? mk(alt_pkg::K_REG, {27'd0, rix[4:0]}, 1'b0, 1'b0)
                        : mk(alt_pkg::K_IDENT, 32'd0, 1'b0, 1'b0);
        tail1  = idle_res;
        tcount = {idle_hit, !idle_hit};
      end else begin
        tail0  = idle_res;
        tcount = {1'b0, idle_hit};
      end
      mode_next         = idle_mode;
      accum_next        = idle_accum;
      radix_next        = idle_radix;
      saturated_next    = 1'b0;
      match_chars_next  = idle_mc;
      match_len_next    = idle_ml;
      pending_char_next = 8'd0;
    end

    n = CountW_L'(pcount) + CountW_L'(tcount);
    batch.count   = n;
    batch.item[0] = (pcount != 2'd0) ? pre0 : tail0;
    batch.item[1] = (pcount == 2'd2) ? pre1 : ((pcount == 2'd1) ? tail0 : tail1);
    batch.item[2] = (pcount == 2'd2) ? tail0 : tail1;
    batch.item[3] = tail1;
    for (int i = 0; i < alt_pkg::MaxResults; i++) begin
      batch.item[i].last = (CountW_L'(i + 1) == n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= alt_pkg::M_IDLE;
      accum        <= 32'd0;
      radix        <= alt_pkg::R_DEC;
      saturated    <= 1'b0;
      match_chars  <= 24'd0;
      match_len    <= 3'd0;
      pending_char <= 8'd0;
    end else if (take) begin
      mode         <= mode_next;
      accum        <= accum_next;
      radix        <= radix_next;
      saturated    <= saturated_next;
      match_chars  <= match_chars_next;
      match_len    <= match_len_next;
      pending_char <= pending_char_next;
    end
  end

endmodule

// File: sv/assembler_line_tokenizer.sv
// ----------------------------------------------------------------------------
// assembler_line_tokenizer
// Character-in, token-out lexer for assembler source lines, with a short
// result queue that drains one token per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   -------  ---------------------  ----------------------------------------
//   input    ch_valid / ch_stall    ch
//   output   tok_valid / tok_stall  kind, value, backward, error, last
//
// One character is taken per cycle while each character yields at most one
// token and the output is not stalled; a character that yields more tokens (up
// to four) stalls input until its final token leaves, the result queue draining
// one token per cycle unless the output stalls. The queue takes a new transaction
// when it is empty or its final entry leaves in the same cycle. Synchronous reset
// clears lexer state and empties the queue. Output stall holds the queue head and backs up input.
module assembler_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        ch_valid,
  output logic        ch_stall,
  input  logic [7:0]  ch,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [3:0]  kind,
  output logic [31:0] value,
  output logic        backward,
  output logic        error,
  output logic        last
);

  localparam int CountW = alt_pkg::CountW;

  alt_pkg::batch_t                          batch;
  alt_pkg::result_t [alt_pkg::MaxResults-1:0] queue;
  logic [CountW-1:0]                        count;
  logic                                     take;
  logic                                     pop;

  assign ch_stall  = (count > CountW'(1)) || (count == CountW'(1) && tok_stall);
  assign take      = ch_valid && !ch_stall;
  assign tok_valid = count != '0;
  assign pop       = tok_valid && !tok_stall;

  alt_core u_core (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .ch    (ch),
    .batch (batch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      queue <= batch.item;
    end else if (pop) begin
      for (int i = 0; i < alt_pkg::MaxResults - 1; i++) begin
        queue[i] <= queue[i + 1];
      end
    end
  end

  assign kind     = queue[0].kind;
  assign value    = queue[0].value;
  assign backward = queue[0].backward;
  assign error    = queue[0].error;
  assign last     = queue[0].last;

`ifndef SYNTH
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    take |=> count == $past(batch.count))
    else $error("queue count does not match loaded batch");

  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && count == CountW'(1)) |-> last)
    else $error("final queued token lacks last flag");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && count > CountW'(1) && !take) |=> tok_valid)
    else $error("queue emptied with tokens outstanding");
`endif

endmodule

// File: verif/tb_assembler_line_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_assembler_line_tokenizer
// Streams source characters into the assembler line tokenizer and checks
// every token against a behavioural lexer kept in the testbench. A short
// directed line hits the awkward corners. Random token lines, some malformed,
// follow, then a stretch with no idling and a long output hold-off that backs
// up the input. Raw byte noise comes last.
// ----------------------------------------------------------------------------
module tb_assembler_line_tokenizer;
  import alt_pkg::*;

  localparam int HoldCycles  = 80;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChNl  = 8'h0a;

  logic        clk;
  logic        rst;
  logic        ch_valid;
  logic        ch_stall;
  logic [7:0]  ch;
  logic        tok_valid;
  logic        tok_stall;
  logic [3:0]  kind;
  logic [31:0] value;
  logic        backward;
  logic        error;
  logic        last;

  assembler_line_tokenizer u_top (
    .clk       (clk),
    .rst       (rst),
    .ch_valid  (ch_valid),
    .ch_stall  (ch_stall),
    .ch        (ch),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .kind      (kind),
    .value     (value),
    .backward  (backward),
    .error     (error),
    .last      (last)
  );

  mode_t       lx_mode;
  logic [31:0] lx_acc;
  radix_t      lx_radix;
  logic        lx_sat;
  logic [23:0] lx_name;
  logic [2:0]  lx_name_len;
  logic [7:0]  lx_held;
  int          char_tokens;

  result_t     tokens_due[$];
  logic [7:0]  line_chars[$];
  string       punct_marks = "+-*/()#&|:=@!?%^~";
  int          failures    = 0;
  int          chars_sent  = 0;
  bit          calm        = 1'b0;
  int          hold_reqs   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (is_digit(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic int radix_digit(logic [7:0] c);
    int d;
    d = hex_digit(c);
    if (d < 0) return -1;
    case (lx_radix)
      R_HEX:   return d;
      R_OCT:   return d < 8 ? d : -1;
      default: return d < 10 ? d : -1;
    endcase
  endfunction

  task automatic lexer_clear();
    lx_mode     = M_IDLE;
    lx_acc      = '0;
    lx_radix    = R_DEC;
    lx_sat      = 1'b0;
    lx_name     = '0;
    lx_name_len = '0;
    lx_held     = '0;
  endtask

  task automatic put_token(kind_t k, logic [31:0] v, logic b, logic e);
    result_t t;
    if (char_tokens < MaxResults) begin
      t.kind     = k;
      t.value    = v;
      t.backward = b;
      t.error    = e;
      t.last     = 1'b0;
      tokens_due.push_back(t);
      char_tokens++;
    end
  endtask

  task automatic add_digit(int d);
    logic [63:0] v;
    if (!lx_sat) begin
      v = lx_acc * (lx_radix == R_HEX ? 64'd16 : lx_radix == R_OCT ? 64'd8 : 64'd10)
          + 64'(d);
      if (v > 64'hffff_ffff) begin
        lx_acc = '1;
        lx_sat = 1'b1;
      end else begin
        lx_acc = v[31:0];
      end
    end
  endtask

  task automatic note_name(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (lx_name_len < 3) lx_name = {lx_name[15:0], u};
    if (lx_name_len < 7) lx_name_len++;
  endtask

  task automatic begin_ident(logic [7:0] c);
    put_token(K_TEXT, {24'd0, c}, 1'b0, 1'b0);
    lx_mode     = M_IDENT;
    lx_name     = '0;
    lx_name_len = '0;
    note_name(c);
  endtask

  function automatic int reg_number();
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    if (lx_name_len == 2) begin
      a = lx_name[15:8];
      b = lx_name[7:0];
      if (a == "S" && b == "P") return 15;
      if (is_digit(b) && a == "A") return b - "0";
      if (is_digit(b) && a == "B") return 16 + b - "0";
    end else if (lx_name_len == 3) begin
      a = lx_name[23:16];
      b = lx_name[15:8];
      d = lx_name[7:0];
      if (b == "1" && a == "A" && d >= "0" && d <= "4") return 10 + d - "0";
      if (b == "1" && a == "B" && d >= "0" && d <= "5") return 26 + d - "0";
    end
    return -1;
  endfunction

  task automatic line_start(logic [7:0] c);
    lexer_clear();
    if (c == " " || c == ChTab) begin
    end else if (is_alpha(c) || c == "_") begin
      begin_ident(c);
    end else if (c == ".") begin
      lx_mode = M_DOT;
    end else if (c == "$") begin
      lx_mode  = M_DOLLAR;
      lx_radix = R_HEX;
    end else if (c == "0") begin
      lx_mode  = M_ZERO;
      lx_radix = R_OCT;
    end else if (is_digit(c)) begin
      lx_mode = M_NUM;
      lx_acc  = {24'd0, c - 8'd48};
    end else if (c == ChNl || c == ChNul) begin
      put_token(K_END, 0, 1'b0, 1'b0);
    end else if (c == ";") begin
      put_token(K_END, 0, 1'b0, 1'b0);
      lx_mode = M_COMMENT;
    end else if (c == "\"") begin
      lx_mode = M_STRING;
    end else if (c == "<") begin
      lx_mode = M_LT;
    end else if (c == ">") begin
      lx_mode = M_GT;
    end else begin
      put_token(K_PUNCT, {24'd0, c}, 1'b0, 1'b0);
    end
  endtask

  task automatic lex_char(logic [7:0] c);
    int d;
    int r;
    bit again;
    char_tokens = 0;
    do begin
      again = 1'b0;
      case (lx_mode)
        M_IDENT: begin
          if (is_word(c)) begin
            put_token(K_TEXT, {24'd0, c}, 1'b0, 1'b0);
            note_name(c);
          end else begin
            r = reg_number();
            if (r >= 0) put_token(K_REG, r, 1'b0, 1'b0);
            else put_token(K_IDENT, 0, 1'b0, 1'b0);
            line_start(c);
          end
        end
        M_DOT: begin
          if (is_word(c)) begin
            begin_ident(".");
            again = 1'b1;
          end else begin
            put_token(K_PUNCT, 32'h2e, 1'b0, 1'b0);
            line_start(c);
          end
        end
        M_DOLLAR: begin
          d = hex_digit(c);
          if (d >= 0) begin
            lx_mode = M_NUM;
            lx_acc  = d;
          end else begin
            put_token(K_NUM, 0, 1'b0, 1'b1);
            line_start(c);
          end
        end
        M_ZERO: begin
          if (c == "x" || c == "X") begin
            lx_mode = M_ZEROX;
            lx_held = c;
          end else begin
            lx_mode = M_NUM;
            again   = 1'b1;
          end
        end
        M_ZEROX: begin
          d = hex_digit(c);
          if (d >= 0) begin
            lx_mode  = M_NUM;
            lx_radix = R_HEX;
            lx_acc   = d;
          end else begin
            put_token(K_NUM, 0, 1'b0, 1'b0);
            begin_ident(lx_held);
            again = 1'b1;
          end
        end
        M_NUM: begin
          d = radix_digit(c);
          if (d >= 0) begin
            add_digit(d);
          end else if (lx_radix != R_HEX &&
                       (c == "f" || c == "F" || c == "b" || c == "B")) begin
            lx_mode = M_LABEL;
            lx_held = c;
          end else begin
            put_token(K_NUM, lx_acc, 1'b0, 1'b0);
            line_start(c);
          end
        end
        M_LABEL: begin
          if (is_word(c)) begin
            put_token(K_NUM, lx_acc, 1'b0, 1'b0);
            begin_ident(lx_held);
            again = 1'b1;
          end else begin
            put_token(K_LABEL, lx_acc, lx_held == "b" || lx_held == "B", 1'b0);
            line_start(c);
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            put_token(K_STR, 0, 1'b0, 1'b0);
            lexer_clear();
          end else if (c == ChNl || c == ChNul) begin
            put_token(K_STR, 0, 1'b0, 1'b1);
            put_token(K_END, 0, 1'b0, 1'b0);
            lexer_clear();
          end else begin
            put_token(K_TEXT, {24'd0, c}, 1'b0, 1'b0);
          end
        end
        M_LT: begin
          if (c == "<") begin
            put_token(K_SHL, 0, 1'b0, 1'b0);
            lexer_clear();
          end else begin
            put_token(K_PUNCT, 32'h3c, 1'b0, 1'b0);
            line_start(c);
          end
        end
        M_GT: begin
          if (c == ">") begin
            put_token(K_SHR, 0, 1'b0, 1'b0);
            lexer_clear();
          end else begin
            put_token(K_PUNCT, 32'h3e, 1'b0, 1'b0);
            line_start(c);
          end
        end
        M_COMMENT: begin
          if (c == ChNl || c == ChNul) lexer_clear();
        end
        default: line_start(c);
      endcase
    end while (again);
    if (char_tokens > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endtask

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (ch_valid === 1'b1 && ch_stall === 1'b0) lex_char(ch);
      if (tok_valid === 1'b1 && tok_stall === 1'b0) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: token with none due: expected nothing, actual kind %0d value %0h",
                   $time, kind, value);
          failures++;
        end else begin
          want = tokens_due.pop_front();
          compare_field("kind", {28'd0, want.kind}, {28'd0, kind});
          compare_field("value", want.value, value);
          compare_field("backward", {31'd0, want.backward}, {31'd0, backward});
          compare_field("error", {31'd0, want.error}, {31'd0, error});
          compare_field("last", {31'd0, want.last}, {31'd0, last});
        end
      end
    end
  end

  initial begin : receiver
    int holds_done;
    holds_done = 0;
    tok_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        tok_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        tok_stall <= !calm && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((ch_valid === 1'b1 && ch_stall === 1'b0) ||
          (tok_valid === 1'b1 && tok_stall === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, StallLimit);
    $display("status: fail");
    $finish;
  end

  task automatic send_char(logic [7:0] c);
    if (!calm && $urandom_range(99) < 9) begin
      ch_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    ch_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (ch_stall !== 1'b0) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_char(line_chars[i]);
    line_chars.delete();
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    return $urandom_range(1) ? (c | 8'h20) : (c & 8'hdf);
  endfunction

  function automatic logic [7:0] rand_digit(int lo, int hi);
    return 8'd48 + 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(15);
    return d < 10 ? 8'd48 + 8'(d) : any_case(8'd55 + 8'(d));
  endfunction

  function automatic logic [7:0] rand_word();
    case ($urandom_range(3))
      0:       return rand_digit(0, 9);
      3:       return "_";
      default: return any_case(8'd65 + 8'($urandom_range(25)));
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
    end while (c == "\"" || c == ChNl);
    return c;
  endfunction

  task automatic add_fragment();
    int n;
    logic [7:0] c;
    case ($urandom_range(10))
      0: begin
        n = $urandom_range(2);
        line_chars.push_back(any_case(n == 0 ? "A" : n == 1 ? "B" : "S"));
        if (n == 2) begin
          line_chars.push_back(any_case("P"));
        end else begin
          if ($urandom_range(1)) line_chars.push_back("1");
          line_chars.push_back(rand_digit(0, 9));
        end
        if ($urandom_range(7) == 0) line_chars.push_back(rand_word());
      end
      1: begin
        if ($urandom_range(3) == 0) line_chars.push_back(".");
        line_chars.push_back($urandom_range(4) == 0 ? "_" : any_case(8'd65 + 8'($urandom_range(25))));
        repeat ($urandom_range(8)) line_chars.push_back(rand_word());
      end
      2: begin
        line_chars.push_back(rand_digit(1, 9));
        repeat ($urandom_range(11)) line_chars.push_back(rand_digit(0, 9));
      end
      3: begin
        if ($urandom_range(1)) begin
          line_chars.push_back("$");
        end else begin
          line_chars.push_back("0");
          line_chars.push_back(any_case("X"));
        end
        repeat ($urandom_range(1, 10)) line_chars.push_back(rand_hex());
      end
      4: begin
        line_chars.push_back("0");
        repeat ($urandom_range(12))
          line_chars.push_back($urandom_range(9) == 0 ? rand_digit(8, 9) : rand_digit(0, 7));
      end
      5: begin
        repeat ($urandom_range(1, 3)) line_chars.push_back(rand_digit(0, 9));
        line_chars.push_back(any_case($urandom_range(1) ? "F" : "B"));
      end
      6: begin
        line_chars.push_back("\"");
        repeat ($urandom_range(6)) line_chars.push_back(text_char());
        if ($urandom_range(5) == 0) line_chars.push_back($urandom_range(1) ? ChNl : ChNul);
        else line_chars.push_back("\"");
      end
      7: begin
        n = $urandom_range(3);
        line_chars.push_back(n[0] ? ">" : "<");
        if (n < 2) line_chars.push_back(n[0] ? ">" : "<");
      end
      8: begin
        n = $urandom_range(3);
        if (n == 0) begin
          line_chars.push_back(8'($urandom_range(128, 255)));
        end else if (n == 1) begin
          do c = 8'($urandom_range(1, 31)); while (c == ChTab || c == ChNl);
          line_chars.push_back(c);
        end else begin
          line_chars.push_back(punct_marks[$urandom_range(punct_marks.len() - 1)]);
        end
      end
      9: begin
        n = $urandom_range(3);
        if (n == 0) begin
          line_chars.push_back("$");
        end else if (n == 3) begin
          line_chars.push_back(".");
        end else begin
          line_chars.push_back("0");
          line_chars.push_back(n == 1 ? "x" : "X");
        end
      end
      default: begin
        line_chars.push_back(";");
        repeat ($urandom_range(5)) line_chars.push_back(text_char());
        line_chars.push_back(ChNl);
      end
    endcase
    case ($urandom_range(5))
      0, 1:    line_chars.push_back(" ");
      2:       line_chars.push_back(ChTab);
      3:       line_chars.push_back(",");
      default: ;
    endcase
  endtask

  task automatic send_token_lines(int count);
    int target;
    target = chars_sent + count;
    while (chars_sent < target) begin
      repeat ($urandom_range(1, 6)) add_fragment();
      line_chars.push_back($urandom_range(7) == 0 ? ChNul : ChNl);
      send_line();
    end
  endtask

  task automatic test_directed();
    string s;
    s = "$g,0xg,08 1f,2b_.x. sp,A14,b15<<>\"q\n;z\n";
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
    line_chars.push_back(8'hff);
    line_chars.push_back(ChNul);
    send_line();
  endtask

  task automatic test_token_lines();
    send_token_lines(100);
  endtask

  task automatic test_quiet_stretch();
    calm = 1'b1;
    send_token_lines(40);
    calm = 1'b0;
  endtask

  task automatic test_back_pressure();
    calm = 1'b1;
    hold_reqs++;
    send_token_lines(40);
    calm = 1'b0;
  endtask

  task automatic test_byte_noise();
    repeat (40) line_chars.push_back(8'($urandom_range(255)));
    send_line();
  endtask

  initial begin
    rst      = 1'b1;
    ch_valid = 1'b0;
    ch       = '0;
    lexer_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_token_lines();
    test_quiet_stretch();
    test_back_pressure();
    test_byte_noise();
    ch_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
